[sv/mvm_pkg.sv]
// Shared constants and the command type of the 8x6 matrix-vector multiplier.
`timescale 1ns / 1ps

package mvm_pkg;

   localparam int COEF_WIDTH   = 16;
   localparam int DATA_WIDTH   = 16;
   localparam int RESULT_WIDTH = 32;
   localparam int NUM_ROWS     = 8;
   localparam int NUM_COLS     = 6;
   localparam int ROW_W        = 3;
   localparam int COL_W        = 3;
   localparam int QUEUE_DEPTH  = 2;

   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(NUM_ROWS - 1);

   // Request kinds carried in the req_type field.
   localparam logic REQ_COMPUTE = 1'b0;
   localparam logic REQ_LOAD    = 1'b1;

   typedef struct packed {
      logic                                 is_load;
      logic [ROW_W-1:0]                     row;
      logic [COL_W-1:0]                     col;
      logic [COEF_WIDTH-1:0]                coef;
      logic [NUM_COLS-1:0][DATA_WIDTH-1:0]  vec;
   } cmd_type;

endpackage

[sv/mvm_if.sv]
// Valid/ready channel interfaces for requests and responses.
`timescale 1ns / 1ps

interface mvm_req_if import mvm_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic                          req_type;
   logic        [ROW_W-1:0]       coef_row;
   logic        [COL_W-1:0]       coef_col;
   logic signed [COEF_WIDTH-1:0]  coef_value;
   logic signed [DATA_WIDTH-1:0]  vec_lin_x;
   logic signed [DATA_WIDTH-1:0]  vec_lin_y;
   logic signed [DATA_WIDTH-1:0]  vec_lin_z;
   logic signed [DATA_WIDTH-1:0]  vec_ang_x;
   logic signed [DATA_WIDTH-1:0]  vec_ang_y;
   logic signed [DATA_WIDTH-1:0]  vec_ang_z;

   modport source (output valid, req_type, coef_row, coef_col, coef_value,
                   vec_lin_x, vec_lin_y, vec_lin_z, vec_ang_x, vec_ang_y, vec_ang_z,
                   input ready);
   modport sink (input valid, req_type, coef_row, coef_col, coef_value,
                 vec_lin_x, vec_lin_y, vec_lin_z, vec_ang_x, vec_ang_y, vec_ang_z,
                 output ready);
endinterface

interface mvm_rsp_if import mvm_pkg::*; ();
   logic                            valid;
   logic                            ready;
   logic signed [RESULT_WIDTH-1:0]  out_0;
   logic signed [RESULT_WIDTH-1:0]  out_1;
   logic signed [RESULT_WIDTH-1:0]  out_2;
   logic signed [RESULT_WIDTH-1:0]  out_3;
   logic signed [RESULT_WIDTH-1:0]  out_4;
   logic signed [RESULT_WIDTH-1:0]  out_5;
   logic signed [RESULT_WIDTH-1:0]  out_6;
   logic signed [RESULT_WIDTH-1:0]  out_7;

   modport source (output valid, out_0, out_1, out_2, out_3, out_4, out_5, out_6, out_7,
                   input ready);
   modport sink (input valid, out_0, out_1, out_2, out_3, out_4, out_5, out_6, out_7,
                 output ready);
endinterface

[sv/matrix_vector_multiply_8x6_top.sv]
// Top level of the 8x6 signed matrix times 6-element vector multiplier.
`timescale 1ns / 1ps

// Usage:
// Requests arrive on req_chan with valid/ready. A load request (req_type 1)
// writes coef_value into row coef_row, column coef_col of the coefficient
// memory and gives no response; a column of 6 or 7 is accepted and ignored.
// A compute request (req_type 0) multiplies the stored matrix by the six
// vector components and gives one response on rsp_chan holding eight
// 32-bit wrapped dot products, out_0 for row 0 through out_7 for row 7.
// Every coefficient must be loaded before a compute that reads it.
// A compute reads the memory one row per cycle while the pipeline is not
// frozen; loads are taken one per cycle while no compute runs and nothing
// is frozen. A new compute is taken as the last row of the one before is
// read. Rows pass the memory read, product and pair-sum registers.
// A two-entry queue sits between acceptance and the row sequencer, so up to
// two requests are still taken while a compute runs or a response waits.
// When rsp_chan stalls, the finished result waits in the output register,
// the next compute runs up to its last row and then holds.
// Reset empties the queue and pipeline; the coefficient memory keeps
// whatever it held and must be reloaded.
module matrix_vector_multiply_8x6_top import mvm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   mvm_req_if.sink     req_chan,
   mvm_rsp_if.source   rsp_chan
);

   logic     push_valid;
   logic     push_ready;
   cmd_type  push_cmd;
   logic     q_valid;
   logic     q_ready;
   cmd_type  q_cmd;

   mvm_front u_front (
      .req        (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   mvm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_cmd    (push_cmd),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_cmd   (q_cmd)
   );

   mvm_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_ready (q_ready),
      .q_cmd   (q_cmd),
      .rsp     (rsp_chan)
   );

endmodule

[sv/mvm_front.sv]
// Request front end: classifies requests and forwards useful ones to the queue.
`timescale 1ns / 1ps

module mvm_front import mvm_pkg::*; (
   mvm_req_if.sink    req,
   output logic       push_valid,
   input  logic       push_ready,
   output cmd_type    push_cmd
);

   logic is_load;
   logic col_ok;

   assign is_load = (req.req_type == REQ_LOAD);
   assign col_ok  = (req.coef_col < COL_W'(NUM_COLS));

   // A load to a column past the matrix is accepted and dropped here.
   assign req.ready  = push_ready;
   assign push_valid = req.valid && (!is_load || col_ok);

   always_comb begin
      push_cmd.is_load = is_load;
      push_cmd.row     = req.coef_row;
      push_cmd.col     = req.coef_col;
      push_cmd.coef    = req.coef_value;
      push_cmd.vec[0]  = req.vec_lin_x;
      push_cmd.vec[1]  = req.vec_lin_y;
      push_cmd.vec[2]  = req.vec_lin_z;
      push_cmd.vec[3]  = req.vec_ang_x;
      push_cmd.vec[4]  = req.vec_ang_y;
      push_cmd.vec[5]  = req.vec_ang_z;
   end

endmodule

[sv/mvm_queue.sv]
// Short command queue between the front end and the compute back end.
`timescale 1ns / 1ps

module mvm_queue import mvm_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  cmd_type  in_cmd,
   output logic     out_valid,
   input  logic     out_ready,
   output cmd_type  out_cmd
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push;
   logic               pop;

   assign in_ready  = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_cmd   = entries_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

[sv/mvm_back.sv]
// Compute back end: coefficient memory, row sequencer, multiply/add pipeline, result register.
`timescale 1ns / 1ps

module mvm_back import mvm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   output logic        q_ready,
   input  cmd_type     q_cmd,
   mvm_rsp_if.source   rsp
);

   localparam int NUM_PAIRS = NUM_COLS / 2;
   localparam int PROD_W    = COEF_WIDTH + DATA_WIDTH;

   function automatic logic [RESULT_WIDTH-1:0] mul_wrap(logic [COEF_WIDTH-1:0] c,
                                                        logic [DATA_WIDTH-1:0] v);
      logic signed [PROD_W-1:0] p;
      logic signed [63:0]       p64;
      p   = signed'(c) * signed'(v);
      p64 = 64'(p);
      return p64[RESULT_WIDTH-1:0];
   endfunction

   // Coefficient memory: one row of six coefficients per word.
   logic [NUM_COLS-1:0][COEF_WIDTH-1:0] mem [NUM_ROWS];

   logic                                 advance;
   logic                                 issue_free;
   logic                                 pop;
   logic                                 start;
   logic                                 load_wr;

   logic                                 busy_ff, busy_in;
   logic [ROW_W-1:0]                     row_cnt_ff, row_cnt_in;
   logic [NUM_COLS-1:0][DATA_WIDTH-1:0]  vec_ff;

   logic                                 b_valid_ff;
   logic [ROW_W-1:0]                     b_row_ff;
   logic [NUM_COLS-1:0][COEF_WIDTH-1:0]  b_coef_ff;
   logic [NUM_COLS-1:0][DATA_WIDTH-1:0]  b_vec_ff;

   logic                                 c_valid_ff;
   logic [ROW_W-1:0]                     c_row_ff;
   logic [RESULT_WIDTH-1:0]              prod_ff [NUM_COLS];

   logic                                 d_valid_ff;
   logic [ROW_W-1:0]                     d_row_ff;
   logic [RESULT_WIDTH-1:0]              part_ff [NUM_PAIRS];
   logic [RESULT_WIDTH-1:0]              row_sum;
   logic                                 d_last;

   logic [RESULT_WIDTH-1:0]              collect_ff [NUM_ROWS-1];
   logic [RESULT_WIDTH-1:0]              out_ff [NUM_ROWS];
   logic                                 rsp_valid_ff, rsp_valid_in;

   assign d_last     = d_valid_ff && (d_row_ff == LAST_ROW);
   // The whole pipeline freezes only when the last row is done and the
   // response register still holds a result nobody has taken.
   assign advance    = !(d_last && rsp_valid_ff && !rsp.ready);
   assign issue_free = !busy_ff || (row_cnt_ff == LAST_ROW);
   assign q_ready    = issue_free && advance;
   assign pop        = q_valid && q_ready;
   assign start      = pop && !q_cmd.is_load;
   assign load_wr    = pop && q_cmd.is_load;

   always_comb begin
      busy_in    = busy_ff;
      row_cnt_in = row_cnt_ff;
      if (advance) begin
         if (busy_ff && (row_cnt_ff != LAST_ROW)) begin
            row_cnt_in = row_cnt_ff + 1'b1;
         end else begin
            busy_in    = start;
            row_cnt_in = '0;
         end
      end
   end

   always_comb begin
      row_sum = '0;
      for (int k = 0; k < NUM_PAIRS; k++) begin
         row_sum = row_sum + part_ff[k];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance && d_last) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         row_cnt_ff   <= '0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         d_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         row_cnt_ff   <= row_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            b_valid_ff <= busy_ff;
            c_valid_ff <= b_valid_ff;
            d_valid_ff <= c_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_wr) begin
         mem[q_cmd.row][q_cmd.col] <= q_cmd.coef;
      end
      if (advance) begin
         b_coef_ff <= mem[row_cnt_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         vec_ff <= q_cmd.vec;
      end
      if (advance) begin
         b_row_ff <= row_cnt_ff;
         b_vec_ff <= vec_ff;
         c_row_ff <= b_row_ff;
         d_row_ff <= c_row_ff;
         for (int j = 0; j < NUM_COLS; j++) begin
            prod_ff[j] <= mul_wrap(b_coef_ff[j], b_vec_ff[j]);
         end
         for (int k = 0; k < NUM_PAIRS; k++) begin
            part_ff[k] <= prod_ff[2*k] + prod_ff[2*k+1];
         end
         if (d_valid_ff && !d_last) begin
            collect_ff[d_row_ff] <= row_sum;
         end
         if (d_last) begin
            for (int r = 0; r < NUM_ROWS - 1; r++) begin
               out_ff[r] <= collect_ff[r];
            end
            out_ff[NUM_ROWS-1] <= row_sum;
         end
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.out_0 = out_ff[0];
   assign rsp.out_1 = out_ff[1];
   assign rsp.out_2 = out_ff[2];
   assign rsp.out_3 = out_ff[3];
   assign rsp.out_4 = out_ff[4];
   assign rsp.out_5 = out_ff[5];
   assign rsp.out_6 = out_ff[6];
   assign rsp.out_7 = out_ff[7];

`ifndef SYNTHESIS
   a_stall_holds_last: assert property (@(posedge clock) disable iff (reset)
      !advance |=> d_valid_ff && (d_row_ff == LAST_ROW))
      else $error("stalled pipeline lost its last row");

   a_row_steps: assert property (@(posedge clock) disable iff (reset)
      busy_ff && advance && (row_cnt_ff != LAST_ROW)
      |=> busy_ff && (row_cnt_ff == $past(row_cnt_ff) + 1'b1))
      else $error("row sequencer skipped or repeated a row");

   a_result_from_last_row: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(d_last))
      else $error("response raised without a finished last row");
`endif

endmodule
